// ===== rtl/core/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants for the literal substitute stream
// Holds the size limits, the register map, the controller states and the
// command and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

    // Size limits of pattern, replacement and the per-item result count.
    localparam int MAX_PATTERN     = 16;
    localparam int MAX_REPLACEMENT = 16;
    localparam int REG_BYTES       = 16;
    localparam int PAT_CAP         = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
    localparam int REP_CAP         = (MAX_REPLACEMENT < REG_BYTES) ? MAX_REPLACEMENT
                                                                   : REG_BYTES;
    localparam int RESULT_CAP      = 16;
    localparam int HELD_DEPTH      = 16;
    localparam int LEN_W           = 5;
    localparam int ADDR_W          = 6;
    localparam int DATA_W          = 64;
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    // Register map, one 64-bit register every eight bytes.
    typedef enum logic [2:0] {
        REG_PAT_LO   = 3'd0,
        REG_PAT_HI   = 3'd1,
        REG_PAT_LEN  = 3'd2,
        REG_REP_LO   = 3'd3,
        REG_REP_HI   = 3'd4,
        REG_REP_LEN  = 3'd5,
        REG_GLOBAL   = 3'd6
    } t_reg_idx;

    // Configuration as seen by the datapath, lengths already saturated.
    typedef struct packed {
        logic [8*REG_BYTES-1:0] pattern;
        logic [LEN_W-1:0]       pat_len;
        logic [8*REG_BYTES-1:0] replacement;
        logic [LEN_W-1:0]       rep_len;
        logic                   global_mode;
    } t_cfg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPL,
        ST_DUMP,
        ST_DONE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic emit_head;
        logic emit_rep;
        logic drop_head;
        logic drop_pat;
        logic set_line;
        logic clr_line;
        logic finish;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic count_zero;
        logic active;
        logic full_match;
        logic part_match;
        logic newline;
        logic rep_more;
        logic emit_ok;
        logic fin_ok;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/core/lss_if.sv =====
// ----------------------------------------------------------------------------
// lss_if: stream channels of the literal substitute stream
// Input channel carries a text byte and a flush flag, output channel carries
// an emitted byte and the end-of-run marker. Both use valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       flush;

    modport source (output valid, output data_byte, output flush, input ready);
    modport sink   (input valid, input data_byte, input flush, output ready);
endinterface

interface lss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lss_cfg.sv =====
// ----------------------------------------------------------------------------
// lss_cfg: configuration register file
// APB-style register port holding pattern, replacement, their lengths and the
// replace-all mode. Lengths are saturated to the supported maximum on output.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lss_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lss_pkg::DATA_W-1:0] pwdata,
    output logic      [lss_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output lss_pkg::t_cfg                   o_cfg
);
    import lss_pkg::*;

    logic [63:0]      r_pat_lo, r_pat_hi, r_rep_lo, r_rep_hi;
    logic [LEN_W-1:0] r_pat_len, r_rep_len;
    logic             r_global;
    logic             w_write;
    t_reg_idx         w_idx;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_idx   = t_reg_idx'(paddr[ADDR_W-1:3]);

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= '0;
            r_rep_lo  <= '0;
            r_rep_hi  <= '0;
            r_rep_len <= '0;
            r_global  <= 1'b0;
        end else if (w_write) begin
            case (w_idx)
                REG_PAT_LO:  r_pat_lo  <= pwdata;
                REG_PAT_HI:  r_pat_hi  <= pwdata;
                REG_PAT_LEN: r_pat_len <= pwdata[LEN_W-1:0];
                REG_REP_LO:  r_rep_lo  <= pwdata;
                REG_REP_HI:  r_rep_hi  <= pwdata;
                REG_REP_LEN: r_rep_len <= pwdata[LEN_W-1:0];
                REG_GLOBAL:  r_global  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (w_idx)
            REG_PAT_LO:  prdata = r_pat_lo;
            REG_PAT_HI:  prdata = r_pat_hi;
            REG_PAT_LEN: prdata = DATA_W'(r_pat_len);
            REG_REP_LO:  prdata = r_rep_lo;
            REG_REP_HI:  prdata = r_rep_hi;
            REG_REP_LEN: prdata = DATA_W'(r_rep_len);
            REG_GLOBAL:  prdata = DATA_W'(r_global);
            default:     prdata = '0;
        endcase
    end

    // Configuration seen by the datapath, lengths saturated.
    always_comb begin
        o_cfg.pattern     = {r_pat_hi, r_pat_lo};
        o_cfg.replacement = {r_rep_hi, r_rep_lo};
        o_cfg.pat_len     = (r_pat_len > LEN_W'(PAT_CAP)) ? LEN_W'(PAT_CAP) : r_pat_len;
        o_cfg.rep_len     = (r_rep_len > LEN_W'(REP_CAP)) ? LEN_W'(REP_CAP) : r_rep_len;
        o_cfg.global_mode = r_global;
    end

endmodule

`default_nettype wire

// ===== rtl/core/lss_ctrl.sv =====
// ----------------------------------------------------------------------------
// lss_ctrl: sequencing controller
// Takes one item at a time, then steps the datapath through scanning,
// replacement output, the end-of-line or flush dump and the run close-out.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_in_flush,
    output logic                o_in_ready,
    input  wire lss_pkg::t_stat i_stat,
    output lss_pkg::t_cmd       o_cmd
);
    import lss_pkg::*;

    t_state r_state, n_state;
    logic   w_emit_head_case;

    // In a scan cycle the head byte leaves unless matching is active and a match is complete or pending.
    assign w_emit_head_case = !i_stat.active ||
                              (!i_stat.full_match && !i_stat.part_match);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_flush ? ST_DUMP : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.count_zero) begin
                    n_state = i_stat.newline ? ST_DUMP : ST_DONE;
                end else if (!w_emit_head_case && i_stat.full_match) begin
                    n_state = ST_REPL;
                end else if (!w_emit_head_case) begin
                    n_state = i_stat.newline ? ST_DUMP : ST_DONE;
                end
            end
            ST_REPL: begin
                if (!i_stat.rep_more) begin
                    n_state = ST_SCAN;
                end
            end
            ST_DUMP: begin
                if (i_stat.count_zero) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_stat.fin_ok) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid && !i_in_flush;
            end
            ST_SCAN: begin
                if (!i_stat.count_zero) begin
                    if (w_emit_head_case) begin
                        o_cmd.emit_head = i_stat.emit_ok;
                        o_cmd.drop_head = i_stat.emit_ok;
                    end else if (i_stat.full_match) begin
                        o_cmd.drop_pat = 1'b1;
                        o_cmd.set_line = 1'b1;
                    end
                end
            end
            ST_REPL: begin
                o_cmd.emit_rep = i_stat.rep_more && i_stat.emit_ok;
            end
            ST_DUMP: begin
                if (i_stat.count_zero) begin
                    o_cmd.clr_line = 1'b1;
                end else begin
                    o_cmd.emit_head = i_stat.emit_ok;
                    o_cmd.drop_head = i_stat.emit_ok;
                end
            end
            ST_DONE: begin
                o_cmd.finish = i_stat.fin_ok;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/lss_dp.sv =====
// ----------------------------------------------------------------------------
// lss_dp: datapath of the literal substitute stream
// Holds the pending bytes, compares them with the pattern, walks the
// replacement and feeds emitted bytes through a one-byte lookahead into the
// output register so that the last byte of a run can be marked.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lss_pkg::t_cfg  i_cfg,
    input  wire lss_pkg::t_cmd  i_cmd,
    input  wire logic [7:0]     i_data_byte,
    output lss_pkg::t_stat      o_stat,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_out_last
);
    import lss_pkg::*;

    localparam int HELD_W = 8 * HELD_DEPTH;

    // Held bytes: byte i sits at bits 8i+7:8i, byte 0 is the oldest.
    logic [HELD_W-1:0]     r_held, n_held;
    logic [LEN_W-1:0]      r_count, n_count;
    logic                  r_line, n_line;
    logic                  r_newline;
    logic [LEN_W-1:0]      r_rep_idx;
    logic                  r_pend_valid;
    logic [7:0]            r_pend_byte;
    logic [LEN_W-1:0]      r_res_cnt;
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_out_last;

    logic [HELD_DEPTH-1:0] w_eq;
    logic [7:0]            w_head;
    logic [7:0]            w_rep_byte;
    logic [7:0]            w_emit_byte;
    logic                  w_keep;
    logic                  w_move;
    logic                  w_out_free;

    function automatic logic [HELD_DEPTH-1:0] prefix_mask(input logic [LEN_W-1:0] n);
        logic [HELD_DEPTH-1:0] m;
        for (int i = 0; i < HELD_DEPTH; i++) begin
            m[i] = (LEN_W'(i) < n);
        end
        return m;
    endfunction

    // Per-position compare of held bytes with the pattern.
    always_comb begin
        for (int i = 0; i < HELD_DEPTH; i++) begin
            w_eq[i] = (r_held[8*i +: 8] == i_cfg.pattern[8*i +: 8]);
        end
    end

    assign w_head     = r_held[7:0];
    assign w_rep_byte = 8'(i_cfg.replacement >> {r_rep_idx[3:0], 3'b000});

    // Match status for the controller.
    always_comb begin
        o_stat.count_zero = (r_count == '0);
        o_stat.active     = (i_cfg.pat_len != '0) && (i_cfg.global_mode || !r_line);
        o_stat.full_match = (r_count >= i_cfg.pat_len) &&
                            (&(w_eq | ~prefix_mask(i_cfg.pat_len)));
        o_stat.part_match = (r_count < i_cfg.pat_len) &&
                            (&(w_eq | ~prefix_mask(r_count)));
        o_stat.newline    = r_newline;
        o_stat.rep_more   = (r_rep_idx < i_cfg.rep_len);
        o_stat.emit_ok    = (r_res_cnt >= LEN_W'(RESULT_CAP)) || !r_pend_valid || w_out_free;
        o_stat.fin_ok     = !r_pend_valid || w_out_free;
    end

    // Held byte store: append, drop one, drop a whole pattern, set or clear the line flag.
    always_comb begin
        n_held  = r_held;
        n_count = r_count;
        n_line  = r_line;
        if (i_cmd.load) begin
            for (int i = 0; i < HELD_DEPTH; i++) begin
                if (r_count[3:0] == 4'(i)) begin
                    n_held[8*i +: 8] = i_data_byte;
                end
            end
            n_count = r_count + 1'b1;
        end
        if (i_cmd.drop_head) begin
            n_held  = r_held >> 8;
            n_count = r_count - 1'b1;
        end
        if (i_cmd.drop_pat) begin
            n_held  = r_held >> {i_cfg.pat_len, 3'b000};
            n_count = (r_count > i_cfg.pat_len) ? r_count - i_cfg.pat_len : '0;
        end
        if (i_cmd.set_line) begin
            n_line = 1'b1;
        end
        if (i_cmd.clr_line) begin
            n_line = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_line  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_line  <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        if (i_cmd.load) begin
            r_newline <= (i_data_byte == NEWLINE_BYTE);
        end
    end

    // Replacement byte index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_idx <= '0;
        end else if (i_cmd.drop_pat) begin
            r_rep_idx <= '0;
        end else if (i_cmd.emit_rep) begin
            r_rep_idx <= r_rep_idx + 1'b1;
        end
    end

    // Emission: bytes past the per-item cap are dropped.
    assign w_emit_byte = i_cmd.emit_rep ? w_rep_byte : w_head;
    assign w_keep      = (i_cmd.emit_head || i_cmd.emit_rep) &&
                         (r_res_cnt < LEN_W'(RESULT_CAP));
    assign w_move      = r_pend_valid && (w_keep || i_cmd.finish);
    assign w_out_free  = !r_out_valid || i_out_ready;

    // Lookahead byte and result count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_res_cnt    <= '0;
        end else begin
            if (w_keep) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_res_cnt <= '0;
            end else if (w_keep) begin
                r_res_cnt <= r_res_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            r_pend_byte <= w_emit_byte;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_byte <= r_pend_byte;
            r_out_last <= i_cmd.finish;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/core/literal_substitute_stream.sv =====
// ----------------------------------------------------------------------------
// literal_substitute_stream: streaming literal find-and-replace
// Replaces each leftmost, non-overlapping occurrence of a configured pattern
// in a byte stream with a configured replacement: all of them, or only the first per line.
//
// Usage:
//   i_in carries one text byte per item, or a flush item that releases every
//   held byte. o_out carries the emitted bytes; last_of_run marks the final
//   byte caused by one input item (an item may cause none, at most 16).
//   The register port sets pattern, replacement, lengths and mode; write it
//   only while no item is in progress.
// Sequencing:
//   One item at a time: an item is scanned, each byte is emitted or dropped at
//   the cap, each completed match gives out the replacement, a newline or flush
//   dumps the held bytes, and the receiver's stalls hold the block. The next item
//   is taken while the last result still waits in the output register.
// Reset and stalls:
//   Synchronous reset clears the registers, the held count and the line
//   state. When the receiver deasserts ready, the block holds in place and
//   loses nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module literal_substitute_stream (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    lss_in_if.sink                          i_in,
    lss_out_if.source                       o_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [lss_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lss_pkg::DATA_W-1:0] pwdata,
    output logic      [lss_pkg::DATA_W-1:0] prdata,
    output logic                            pready
);
    import lss_pkg::*;

    t_cfg  w_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;
    logic  w_out_valid;
    logic  [7:0] w_out_byte;
    logic  w_out_last;

    // Register file.
    lss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Controller.
    lss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_flush (i_in.flush),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    lss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .i_data_byte (i_in.data_byte),
        .o_stat      (w_stat),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_out.ready),
        .o_out_byte  (w_out_byte),
        .o_out_last  (w_out_last)
    );

    // Channel hookup.
    assign i_in.ready        = w_in_ready;
    assign o_out.valid       = w_out_valid;
    assign o_out.out_byte    = w_out_byte;
    assign o_out.last_of_run = w_out_last;

endmodule

`default_nettype wire
